[design/lmsfw_pkg.sv]
package lmsfw_pkg;

  localparam int unsigned FrameW  = 14;
  localparam int unsigned CmdBits = 12;
  localparam int unsigned RamBits = 14;
  localparam int unsigned CntW    = $clog2(FrameW + 1);
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned InitLen = 5;
  localparam int unsigned IdxW    = $clog2(InitLen);

  localparam logic [2:0] HdrCmd = 3'b100;
  localparam logic [2:0] HdrRam = 3'b101;
  localparam logic [3:0] MagMax = 4'd8;

  typedef enum logic [1:0] {
    CmdSend   = 2'd0,
    CmdRam    = 2'd1,
    CmdColumn = 2'd2,
    CmdInit   = 2'd3
  } command_e;

  typedef struct packed {
    command_e    command;
    logic [7:0]  command_code;
    logic [6:0]  ram_address;
    logic [3:0]  nibble;
    logic [5:0]  column;
    logic [7:0]  magnitude;
  } req_t;

  typedef struct packed {
    logic [FrameW-1:0] bits;
    logic              is_cmd;
    logic              last;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  function automatic logic [7:0] init_code(logic [IdxW-1:0] idx);
    logic [7:0] code;
    case (idx)
      IdxW'(0): code = 8'h01;
      IdxW'(1): code = 8'h20;
      IdxW'(2): code = 8'h03;
      IdxW'(3): code = 8'h08;
      IdxW'(4): code = 8'hBF;
      default:  code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [FrameW-1:0] cmd_word(logic [7:0] code);
    return {HdrCmd, code, 1'b0, {(FrameW - CmdBits){1'b0}}};
  endfunction

  function automatic logic [FrameW-1:0] ram_word(logic [6:0] addr, logic [3:0] nib);
    return {HdrRam, addr, nib};
  endfunction

endpackage

[design/lmsfw_req_if.sv]
interface lmsfw_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] command_code;
  logic [6:0] ram_address;
  logic [3:0] nibble;
  logic [5:0] column;
  logic [7:0] magnitude;

  modport source (
    output valid, command, command_code, ram_address, nibble, column, magnitude,
    input  ready
  );
  modport sink (
    input  valid, command, command_code, ram_address, nibble, column, magnitude,
    output ready
  );
endinterface

[design/lmsfw_bit_if.sv]
interface lmsfw_bit_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic frame_end;
  logic last;

  modport source (
    output valid, data_bit, frame_end, last,
    input  ready
  );
  modport sink (
    input  valid, data_bit, frame_end, last,
    output ready
  );
endinterface

[design/lmsfw_front.sv]
module lmsfw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lmsfw_req_if.sink            req,
  input  logic                 q_full_i,
  output lmsfw_pkg::push_t     push_o
);
  import lmsfw_pkg::*;

  logic            pend_q, pend_d;
  req_t            req_q, req_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            push;
  logic            last_frame;
  frame_t          frame;
  logic [3:0]      mag_sat;
  logic [7:0]      mask;
  logic            accept;

  always_comb begin
    mag_sat = (req_q.magnitude > 8'(MagMax)) ? MagMax : req_q.magnitude[3:0];
    for (int i = 0; i < 8; i++) begin
      mask[i] = (4'(i) < mag_sat);
    end
  end

  always_comb begin
    frame      = '0;
    last_frame = 1'b1;
    case (req_q.command)
      CmdSend: begin
        frame.bits   = cmd_word(req_q.command_code);
        frame.is_cmd = 1'b1;
      end
      CmdRam: begin
        frame.bits = ram_word(req_q.ram_address, req_q.nibble);
      end
      CmdColumn: begin
        frame.bits = ram_word({req_q.column, idx_q[0]}, idx_q[0] ? mask[7:4] : mask[3:0]);
        last_frame = idx_q[0];
      end
      CmdInit: begin
        frame.bits   = cmd_word(init_code(idx_q));
        frame.is_cmd = 1'b1;
        last_frame   = (idx_q == IdxW'(InitLen - 1));
      end
      default: begin
        frame.bits   = cmd_word(req_q.command_code);
        frame.is_cmd = 1'b1;
      end
    endcase
    frame.last = last_frame;
  end

  assign push         = pend_q && !q_full_i;
  assign req.ready    = !pend_q || (push && last_frame);
  assign accept       = req.valid && req.ready;
  assign push_o.valid = push;
  assign push_o.frame = frame;

  always_comb begin
    pend_d = pend_q;
    idx_d  = idx_q;
    req_d  = req_q;
    if (push) begin
      if (last_frame) begin
        pend_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (accept) begin
      pend_d             = 1'b1;
      idx_d              = '0;
      req_d.command      = command_e'(req.command);
      req_d.command_code = req.command_code;
      req_d.ram_address  = req.ram_address;
      req_d.nibble       = req.nibble;
      req_d.column       = req.column;
      req_d.magnitude    = req.magnitude;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      pend_q <= pend_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule

[design/lmsfw_fifo.sv]
module lmsfw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmsfw_pkg::push_t  push_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output lmsfw_pkg::frame_t head_o
);
  import lmsfw_pkg::*;

  frame_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i.valid && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

endmodule

[design/lmsfw_back.sv]
module lmsfw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lmsfw_pkg::frame_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  lmsfw_bit_if.source       res
);
  import lmsfw_pkg::*;

  logic              active_q, active_d;
  logic [FrameW-1:0] sh_q, sh_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              last_q, last_d;
  logic              ov_q, ov_d;
  logic              bit_q, bit_d;
  logic              fe_q, fe_d;
  logic              rl_q, rl_d;
  logic              advance;
  logic              final_bit;
  logic              load;

  assign advance   = !ov_q || res.ready;
  assign final_bit = (cnt_q == CntW'(1));
  assign load      = !empty_i && (!active_q || (advance && final_bit));
  assign pop_o     = load;

  always_comb begin
    active_d = active_q;
    sh_d     = sh_q;
    cnt_d    = cnt_q;
    last_d   = last_q;
    ov_d     = ov_q;
    bit_d    = bit_q;
    fe_d     = fe_q;
    rl_d     = rl_q;
    if (advance) begin
      ov_d  = active_q;
      bit_d = sh_q[FrameW-1];
      fe_d  = final_bit;
      rl_d  = final_bit && last_q;
      if (active_q) begin
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (final_bit) begin
          active_d = 1'b0;
        end
      end
    end
    if (load) begin
      active_d = 1'b1;
      sh_d     = head_i.bits;
      cnt_d    = head_i.is_cmd ? CntW'(CmdBits) : CntW'(RamBits);
      last_d   = head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    last_q <= last_d;
    bit_q  <= bit_d;
    fe_q   <= fe_d;
    rl_q   <= rl_d;
  end

  assign res.valid     = ov_q;
  assign res.data_bit  = bit_q;
  assign res.frame_end = fe_q;
  assign res.last      = rl_q;

endmodule

[design/led_matrix_serial_frame_writer_core.sv]
// Channel  Dir  Transaction
// req_i    in   one request: command, command_code, ram_address, nibble, column, magnitude
// res_o    out  one write strobe: data_bit, frame_end, last
//
// One strobe per cycle while res_o is ready. Command frames carry 12 bits, RAM write
// frames 14; a column request makes 2 RAM frames, an init request 5 command frames;
// frames follow with no gap while queued. The back-end bit serialiser sets the rate;
// a two-entry frame queue lets the front end expand the next request as bits go out.
// Reset empties the queue and drops any request in progress.
// A stalled res_o holds its strobe; req_i waits while the front end still pushes the
// earlier frames of the previous request, and while the queue is full.
module led_matrix_serial_frame_writer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  lmsfw_req_if.sink   req_i,
  lmsfw_bit_if.source res_o
);
  import lmsfw_pkg::*;

  push_t  push;
  frame_t head;
  logic   q_full;
  logic   q_empty;
  logic   pop;

  lmsfw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  lmsfw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  lmsfw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .res     (res_o)
  );

endmodule

[design/lmsfw_checker.sv]
module lmsfw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic data_bit_i,
  input logic frame_end_i,
  input logic last_i
);

  logic start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
    end else if (out_valid_i && out_ready_i) begin
      start_q <= frame_end_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_bit_i)
      && $stable(frame_end_i) && $stable(last_i))
    else $error("stalled strobe changed");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> frame_end_i)
    else $error("last without frame end");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && start_q |-> data_bit_i && !frame_end_i)
    else $error("frame does not open with a one");

endmodule

bind led_matrix_serial_frame_writer_core lmsfw_checker u_lmsfw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .data_bit_i  (res_o.data_bit),
  .frame_end_i (res_o.frame_end),
  .last_i      (res_o.last)
);

[dv/tb_led_matrix_serial_frame_writer_core.sv]
module tb_led_matrix_serial_frame_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lmsfw_pkg::*;

  typedef struct packed {
    logic data_bit;
    logic frame_end;
    logic last;
  } strobe_t;

  class strobe_scoreboard;
    localparam logic [2:0] CmdHeader = 3'b100;
    localparam logic [2:0] RamHeader = 3'b101;

    strobe_t     strobe_q[$];
    logic [13:0] word_q[$];
    int unsigned len_q[$];
    int unsigned failures = 0;

    function void add_cmd_frame(logic [7:0] code);
      word_q.push_back({CmdHeader, code, 1'b0, 2'b00});
      len_q.push_back(12);
    endfunction

    function void add_ram_frame(logic [6:0] addr, logic [3:0] nib);
      word_q.push_back({RamHeader, addr, nib});
      len_q.push_back(14);
    endfunction

    function void note_request(req_t r);
      logic [7:0] init_seq [5];
      logic [3:0] height;
      logic [8:0] bar;
      strobe_t    s;
      init_seq = '{8'h01, 8'h20, 8'h03, 8'h08, 8'hBF};
      word_q.delete();
      len_q.delete();
      case (r.command)
        CmdSend: add_cmd_frame(r.command_code);
        CmdRam:  add_ram_frame(r.ram_address, r.nibble);
        CmdColumn: begin
          height = (r.magnitude > 8'd8) ? 4'd8 : r.magnitude[3:0];
          bar = (9'd1 << height) - 9'd1;
          add_ram_frame({r.column, 1'b0}, bar[3:0]);
          add_ram_frame({r.column, 1'b1}, bar[7:4]);
        end
        default: begin
          foreach (init_seq[i]) add_cmd_frame(init_seq[i]);
        end
      endcase
      foreach (word_q[f]) begin
        for (int k = 0; k < len_q[f]; k++) begin
          s.data_bit  = word_q[f][13 - k];
          s.frame_end = (k == len_q[f] - 1);
          s.last      = s.frame_end && (f == word_q.size() - 1);
          strobe_q.push_back(s);
        end
      end
    endfunction

    function void check_strobe(logic data_bit, logic frame_end, logic last);
      strobe_t want;
      if (strobe_q.size() == 0) begin
        $error("unexpected strobe: data_bit=%0b frame_end=%0b last=%0b",
               data_bit, frame_end, last);
        failures++;
        return;
      end
      want = strobe_q.pop_front();
      if (data_bit !== want.data_bit) begin
        $error("data_bit: expected %0b, got %0b", want.data_bit, data_bit);
        failures++;
      end
      if (frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, frame_end);
        failures++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return strobe_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lmsfw_req_if req_if ();
  lmsfw_bit_if res_if ();

  strobe_scoreboard book = new();
  bit req_calm = 1'b0;
  bit res_calm = 1'b0;

  led_matrix_serial_frame_writer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    req_if.valid        = 1'b0;
    req_if.command      = '0;
    req_if.command_code = '0;
    req_if.ram_address  = '0;
    req_if.nibble       = '0;
    req_if.column       = '0;
    req_if.magnitude    = '0;
    res_if.ready        = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20)      r.command = CmdSend;
    else if (pick < 45) r.command = CmdRam;
    else if (pick < 85) r.command = CmdColumn;
    else                r.command = CmdInit;
    r.command_code = 8'($urandom_range(0, 255));
    r.ram_address  = 7'($urandom_range(0, 127));
    r.nibble       = 4'($urandom_range(0, 15));
    r.column       = 6'($urandom_range(0, 63));
    r.magnitude    = 8'($urandom_range(0, 1) ? $urandom_range(0, 10)
                                             : $urandom_range(0, 255));
    return r;
  endfunction

  task automatic drive_request(req_t r);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
    gap = req_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.command      <= r.command;
    req_if.command_code <= r.command_code;
    req_if.ram_address  <= r.ram_address;
    req_if.nibble       <= r.nibble;
    req_if.column       <= r.column;
    req_if.magnitude    <= r.magnitude;
    do @(posedge clk_i); while (!req_if.ready);
    book.note_request(r);
    @(negedge clk_i);
  endtask

  // unused fields stay random
  task automatic send_directed(command_e op, int unsigned a, int unsigned b);
    req_t r;
    r = random_request();
    r.command = op;
    case (op)
      CmdSend: r.command_code = 8'(a);
      CmdRam: begin
        r.ram_address = 7'(a);
        r.nibble      = 4'(b);
      end
      CmdColumn: begin
        r.column    = 6'(a);
        r.magnitude = 8'(b);
      end
      default: ;
    endcase
    drive_request(r);
  endtask

  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 31) == 0) res_calm = !res_calm;
      gap = res_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      book.check_strobe(res_if.data_bit, res_if.frame_end, res_if.last);
    end
  end

  initial begin
    @(posedge rst_ni);
    @(negedge clk_i);
    send_directed(CmdSend, 8'h00, 0);
    send_directed(CmdSend, 8'hFF, 0);
    send_directed(CmdSend, 8'hA5, 0);
    send_directed(CmdSend, 8'h5A, 0);
    send_directed(CmdRam, 7'd0, 4'd0);
    send_directed(CmdRam, 7'd127, 4'd15);
    send_directed(CmdRam, 7'h55, 4'hA);
    send_directed(CmdRam, 7'h2A, 4'h5);
    send_directed(CmdColumn, 0, 0);
    send_directed(CmdColumn, 63, 8);
    send_directed(CmdColumn, 21, 1);
    send_directed(CmdColumn, 42, 2);
    send_directed(CmdColumn, 5, 3);
    send_directed(CmdColumn, 17, 4);
    send_directed(CmdColumn, 30, 5);
    send_directed(CmdColumn, 9, 6);
    send_directed(CmdColumn, 50, 7);
    send_directed(CmdColumn, 63, 9);
    send_directed(CmdColumn, 0, 255);
    send_directed(CmdColumn, 36, 128);
    send_directed(CmdInit, 0, 0);
    send_directed(CmdInit, 0, 0);
    repeat (300) drive_request(random_request());
    req_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (book.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
